>>> src/rotor_effectiveness_column_macros.svh
// ----------------------------------------------------------------------------
// rotor_effectiveness_column_macros.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ROTOR_EFFECTIVENESS_COLUMN_MACROS_SVH
`define ROTOR_EFFECTIVENESS_COLUMN_MACROS_SVH

// same-cycle implication, off during reset
`define REFFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reffc check failed");

// next-cycle implication, off during reset
`define REFFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reffc check failed");

`endif

>>> src/reffc_pkg.sv
// ----------------------------------------------------------------------------
// reffc_pkg
// Word types, register codes and Q16.16 helpers for the rotor column block.
// ----------------------------------------------------------------------------
package reffc_pkg;

  typedef struct packed {
    logic [3:0]         rotor_index;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] ct_coef;
    logic signed [31:0] km_coef;
    logic               last_rotor;
  } rotor_t;

  typedef struct packed {
    logic [4:0]         column;
    logic               in_range;
    logic               written;
    logic signed [31:0] roll_moment;
    logic signed [31:0] pitch_moment;
    logic signed [31:0] yaw_moment;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               last_column;
  } column_t;

  localparam logic [2:0] REG_TORQUE_OFF     = 3'd0;
  localparam logic [2:0] REG_TORQUE_OFF_NUP = 3'd1;
  localparam logic [2:0] REG_YAW_ENTRY_OFF  = 3'd2;
  localparam logic [2:0] REG_COLLAPSE       = 3'd3;
  localparam logic [2:0] REG_START_COLUMN   = 3'd4;

  localparam logic [3:0]  AUX_FIRST_INDEX = 4'd4;
  localparam logic [16:0] UP_TILT_LIMIT   = 17'd6554;
  localparam logic [16:0] UP_Z_LIMIT      = 17'd32768;
  localparam logic [4:0]  NORM_MSB        = 5'd29;

  // Q32 -> Q16.16, round half up (floor of (x + 0.5 lsb))
  function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] x);
    logic signed [63:0] t;
    t = x + 64'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

>>> src/rotor_effectiveness_column.sv
// ----------------------------------------------------------------------------
// rotor_effectiveness_column
// Pipelined effectiveness column of one rotor, Q16.16, APB register port.
// ----------------------------------------------------------------------------
// One rotor word in, one column word out, in order. A new word is taken every
// cycle while rotor_ready is high. The depth is set by the axis normalization:
// a 31-stage square root (one root bit per stage) followed by a 17-stage
// divider (one quotient bit per stage, three lanes), then four multiply/round
// stages. When the output word is held by the sink the whole pipeline freezes;
// rotor_ready is high whenever the output register is empty or being drained.
// Registers (byte address 4*i): torque_off, torque_off_non_upward,
// yaw_entry_off, collapse_thrust, start_column; write them only while the
// pipeline is empty.
module rotor_effectiveness_column #(
  parameter int ACTUATOR_COLUMNS = 16,
  parameter int MAX_ROTORS       = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rotor_valid,
  output logic                rotor_ready,
  input  reffc_pkg::rotor_t   rotor,
  output logic                col_valid,
  input  logic                col_ready,
  output reffc_pkg::column_t  col,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import reffc_pkg::*;

  localparam int SQ  = 31;               // root bits
  localparam int DV  = 17;               // quotient bits
  localparam int NST = 5 + SQ + 1 + DV + 1 + 3 + 1;
  localparam int S_SQ_LAST = 4 + SQ;     // stage of last root step
  localparam int S_DV_LAST = S_SQ_LAST + 1 + DV;

  // per-word data that rides along the pipe
  typedef struct packed {
    logic               cond;
    logic               aux;
    logic               in_range;
    logic               last;
    logic [4:0]         column;
    logic [2:0]         sgn;
    logic signed [31:0] ct;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] ctk;
    logic signed [31:0] aux4;
    logic [2:0][29:0]   mn;
  } side_t;

  // ---------------- registers ----------------
  logic       torque_off, torque_off_nup, yaw_entry_off, collapse_thrust;
  logic [3:0] start_column;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      torque_off      <= 1'b0;
      torque_off_nup  <= 1'b0;
      yaw_entry_off   <= 1'b0;
      collapse_thrust <= 1'b0;
      start_column    <= 4'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_TORQUE_OFF:     torque_off      <= pwdata[0];
        REG_TORQUE_OFF_NUP: torque_off_nup  <= pwdata[0];
        REG_YAW_ENTRY_OFF:  yaw_entry_off   <= pwdata[0];
        REG_COLLAPSE:       collapse_thrust <= pwdata[0];
        REG_START_COLUMN:   start_column    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TORQUE_OFF:     prdata = {31'd0, torque_off};
      REG_TORQUE_OFF_NUP: prdata = {31'd0, torque_off_nup};
      REG_YAW_ENTRY_OFF:  prdata = {31'd0, yaw_entry_off};
      REG_COLLAPSE:       prdata = {31'd0, collapse_thrust};
      REG_START_COLUMN:   prdata = {28'd0, start_column};
      default:            prdata = 32'd0;
    endcase
  end

  // ---------------- flow control ----------------
  // Global stall: every stage moves together, valid bits shift with data.
  logic [NST-1:0] vld;
  logic           en;

  assign en          = !vld[NST-1] || col_ready;
  assign rotor_ready = en;
  assign col_valid   = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], rotor_valid};
    end
  end

  // ---------------- stage 0: decode and magnitudes ----------------
  side_t             side_in;
  side_t             side [NST-1];
  logic [2:0][31:0]  mag0;
  logic signed [31:0] km0;
  logic [4:0]        col_in;
  logic              rng_in;

  assign col_in = 5'(start_column) + 5'(rotor.rotor_index);
  assign rng_in = ({1'b0, col_in} < 6'(ACTUATOR_COLUMNS)) &&
                  ({2'b0, rotor.rotor_index} < 6'(MAX_ROTORS));

  always_comb begin
    side_in          = '0;
    side_in.in_range = rng_in;
    side_in.cond     = rng_in && ((|rotor.axis_x) || (|rotor.axis_y) || (|rotor.axis_z))
                       && (|rotor.ct_coef);
    side_in.aux      = rotor.rotor_index >= AUX_FIRST_INDEX;
    side_in.last     = rotor.last_rotor;
    side_in.column   = col_in;
    side_in.sgn      = {rotor.axis_z[31], rotor.axis_y[31], rotor.axis_x[31]};
    side_in.ct       = rotor.ct_coef;
    side_in.px       = rotor.pos_x;
    side_in.py       = rotor.pos_y;
    side_in.pz       = rotor.pos_z;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag0[0] <= rotor.axis_x[31] ? 32'(-rotor.axis_x) : 32'(rotor.axis_x);
      mag0[1] <= rotor.axis_y[31] ? 32'(-rotor.axis_y) : 32'(rotor.axis_y);
      mag0[2] <= rotor.axis_z[31] ? 32'(-rotor.axis_z) : 32'(rotor.axis_z);
      km0     <= rotor.km_coef;
    end
  end

  // ---------------- stage 1: leading one of the largest magnitude ----------------
  logic [31:0]        mx0;
  logic [4:0]         msb_c;
  logic [4:0]         msb1;
  logic [2:0][31:0]   mag1;
  logic signed [63:0] p_ctkm1, p_ctpy1;

  always_comb begin
    mx0 = mag0[0];
    if (mag0[1] > mx0) mx0 = mag0[1];
    if (mag0[2] > mx0) mx0 = mag0[2];
    msb_c = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mx0[i]) msb_c = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      msb1    <= msb_c;
      mag1    <= mag0;
      p_ctkm1 <= 64'(side[0].ct) * 64'(km0);
      p_ctpy1 <= 64'(side[0].ct) * 64'(side[0].py);
    end
  end

  // ---------------- stage 2: normalize largest to [2^29, 2^30) ----------------
  logic [2:0][29:0] mn_c;
  side_t            side2_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (msb1 > NORM_MSB) begin
        mn_c[k] = 30'(mag1[k] >> (msb1 - NORM_MSB));
      end else begin
        mn_c[k] = 30'(mag1[k] << (NORM_MSB - msb1));
      end
    end
  end

  always_comb begin
    side2_c      = side[1];
    side2_c.mn   = mn_c;
    side2_c.ctk  = sat32(rnd_q16(p_ctkm1));
    side2_c.aux4 = sat32(-rnd_q16(p_ctpy1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < NST - 1; i++) begin
        if (i == 2) begin
          side[i] <= side2_c;
        end else begin
          side[i] <= side[i-1];
        end
      end
    end
  end

  // ---------------- stages 3,4: sum of squares ----------------
  logic [2:0][59:0] sq3;
  logic [61:0]      sum4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        sq3[k] <= 60'(side[2].mn[k]) * 60'(side[2].mn[k]);
      end
      sum4 <= 62'(sq3[0]) + 62'(sq3[1]) + 62'(sq3[2]);
    end
  end

  // ---------------- square root, one bit per stage ----------------
  logic [34:0] sq_rem  [SQ];
  logic [30:0] sq_root [SQ];
  logic [61:0] sq_sum  [SQ];

  for (genvar j = 0; j < SQ; j++) begin : g_sq
    logic [34:0] rin;
    logic [30:0] rpr;
    logic [61:0] spr;
    logic [34:0] trial;
    if (j == 0) begin : g_first
      assign rpr = '0;
      assign spr = sum4;
      assign rin = {33'd0, sum4[61:60]};
    end else begin : g_next
      assign rpr = sq_root[j-1];
      assign spr = sq_sum[j-1];
      assign rin = {sq_rem[j-1][32:0], sq_sum[j-1][61-2*j -: 2]};
    end
    assign trial = {2'b00, rpr, 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          sq_rem[j]  <= rin - trial;
          sq_root[j] <= {rpr[29:0], 1'b1};
        end else begin
          sq_rem[j]  <= rin;
          sq_root[j] <= {rpr[29:0], 1'b0};
        end
        sq_sum[j] <= spr;
      end
    end
  end

  // ---------------- divider setup: m*2^16 + n/2 ----------------
  logic [46:0] dv_d [3];
  logic [30:0] dv_n;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        dv_d[k] <= {1'b0, side[S_SQ_LAST].mn[k], 16'd0} + 47'(sq_root[SQ-1][30:1]);
      end
      dv_n <= sq_root[SQ-1];
    end
  end

  // ---------------- restoring divide, three lanes ----------------
  logic [30:0] dv_rem [DV][3];
  logic [16:0] dv_q   [DV][3];
  logic [46:0] dv_lo  [DV][3];
  logic [30:0] dv_nn  [DV][3];

  for (genvar t = 0; t < DV; t++) begin : g_dv
    for (genvar k = 0; k < 3; k++) begin : g_lane
      logic [30:0] rpr;
      logic [46:0] dpr;
      logic [16:0] qpr;
      logic [30:0] npr;
      logic [31:0] rin;
      if (t == 0) begin : g_first
        assign rpr = {1'b0, dv_d[k][46:17]};
        assign dpr = dv_d[k];
        assign qpr = '0;
        assign npr = dv_n;
      end else begin : g_next
        assign rpr = dv_rem[t-1][k];
        assign dpr = dv_lo[t-1][k];
        assign qpr = dv_q[t-1][k];
        assign npr = dv_nn[t-1][k];
      end
      assign rin = {rpr, dpr[16-t]};
      always_ff @(posedge clk) begin
        if (en) begin
          if (rin >= {1'b0, npr}) begin
            dv_rem[t][k] <= 31'(rin - {1'b0, npr});
            dv_q[t][k]   <= {qpr[15:0], 1'b1};
          end else begin
            dv_rem[t][k] <= rin[30:0];
            dv_q[t][k]   <= {qpr[15:0], 1'b0};
          end
          dv_lo[t][k] <= dpr;
          dv_nn[t][k] <= npr;
        end
      end
    end
  end

  // ---------------- unit axis and upward test ----------------
  logic signed [17:0] u_q [3];
  logic               up_q;
  logic [16:0]        qf [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qf[k] = dv_q[DV-1][k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= side[S_DV_LAST].sgn[k] ? -$signed({1'b0, qf[k]}) : $signed({1'b0, qf[k]});
      end
      up_q <= (qf[0] < UP_TILT_LIMIT) && (qf[1] < UP_TILT_LIMIT) &&
              side[S_DV_LAST].sgn[2] && (qf[2] > UP_Z_LIMIT);
    end
  end

  // ---------------- X1: products ----------------
  localparam int S_U = S_DV_LAST + 1;
  logic signed [63:0] cr [6];
  logic signed [63:0] pcu [3];
  logic signed [63:0] pku [3];
  logic signed [31:0] ctk_eff;

  assign ctk_eff = (torque_off || (torque_off_nup && !up_q)) ? 32'sd0 : side[S_U].ctk;

  always_ff @(posedge clk) begin
    if (en) begin
      cr[0] <= 64'(side[S_U].py) * 64'(u_q[2]);
      cr[1] <= 64'(side[S_U].pz) * 64'(u_q[1]);
      cr[2] <= 64'(side[S_U].pz) * 64'(u_q[0]);
      cr[3] <= 64'(side[S_U].px) * 64'(u_q[2]);
      cr[4] <= 64'(side[S_U].px) * 64'(u_q[1]);
      cr[5] <= 64'(side[S_U].py) * 64'(u_q[0]);
      for (int k = 0; k < 3; k++) begin
        pcu[k] <= 64'(side[S_U].ct) * 64'(u_q[k]);
        pku[k] <= 64'(ctk_eff) * 64'(u_q[k]);
      end
    end
  end

  // ---------------- X2: cross product and rounding ----------------
  logic signed [31:0] cx [3];
  logic signed [31:0] ftu2 [3];
  logic signed [63:0] fku2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cx[k]   <= sat32(rnd_q16(cr[2*k] - cr[2*k+1]));
        ftu2[k] <= sat32(rnd_q16(pcu[k]));
        fku2[k] <= rnd_q16(pku[k]);
      end
    end
  end

  // ---------------- X3: ct times cross product ----------------
  localparam int S_X2 = S_U + 2;
  logic signed [63:0] ctc [3];
  logic signed [31:0] ftu3 [3];
  logic signed [63:0] fku3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ctc[k]  <= 64'(side[S_X2].ct) * 64'(cx[k]);
        ftu3[k] <= ftu2[k];
        fku3[k] <= fku2[k];
      end
    end
  end

  // ---------------- output register ----------------
  localparam int S_X3 = S_X2 + 1;
  column_t out_c;
  column_t out_q;
  side_t   sx;

  always_comb begin
    sx                 = side[S_X3];
    out_c              = '0;
    out_c.column       = sx.column;
    out_c.in_range     = sx.in_range;
    out_c.written      = sx.cond;
    out_c.last_column  = sx.last;
    if (sx.cond) begin
      if (sx.aux) begin
        out_c.force_x = sx.ct;
        out_c.force_y = sx.aux4;
      end else begin
        out_c.roll_moment  = sat32(rnd_q16(ctc[0]) - fku3[0]);
        out_c.pitch_moment = sat32(rnd_q16(ctc[1]) - fku3[1]);
        out_c.yaw_moment   = yaw_entry_off ? 32'sd0 : sat32(rnd_q16(ctc[2]) - fku3[2]);
        if (collapse_thrust) begin
          out_c.force_z = sat32(-64'(sx.ct));
        end else begin
          out_c.force_x = ftu3[0];
          out_c.force_y = ftu3[1];
          out_c.force_z = ftu3[2];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q <= out_c;
    end
  end

  assign col = out_q;

endmodule

>>> src/reffc_checker.sv
// ----------------------------------------------------------------------------
// reffc_checker
// Port-level checks of the rotor column block, bound to its top level.
// ----------------------------------------------------------------------------
`include "rotor_effectiveness_column_macros.svh"

module reffc_checker (
  input logic               clk,
  input logic               rst,
  input logic               rotor_ready,
  input logic               col_valid,
  input logic               col_ready,
  input reffc_pkg::column_t col
);
  import reffc_pkg::*;

  // held word must not move
  `REFFC_ASSERT_NXT(a_col_hold, col_valid && !col_ready, col_valid && $stable(col))
  // a filled column is always an in-range one
  `REFFC_ASSERT_IMP(a_written_in_range, col_valid && col.written, col.in_range)
  // unwritten columns carry no entries
  `REFFC_ASSERT_IMP(a_unwritten_zero, col_valid && !col.written, (col.roll_moment == 0) && (col.pitch_moment == 0) && (col.yaw_moment == 0) && (col.force_x == 0) && (col.force_y == 0) && (col.force_z == 0))
  // input side only stalls while a word waits at the output
  `REFFC_ASSERT_IMP(a_ready_stall, !rotor_ready, col_valid && !col_ready)

endmodule

bind rotor_effectiveness_column reffc_checker u_reffc_checker (
  .clk         (clk),
  .rst         (rst),
  .rotor_ready (rotor_ready),
  .col_valid   (col_valid),
  .col_ready   (col_ready),
  .col         (col)
);
